// File: design/csma_mac_pkg.sv
// Shared constants, codes and types of the CSMA stop-and-wait MAC controller.
`timescale 1ns / 1ps
`default_nettype none
package csma_mac_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] OP_SUBMIT      = 3'd0;
    localparam logic [2:0] OP_CS_REPLY    = 3'd1;
    localparam logic [2:0] OP_ACK         = 3'd2;
    localparam logic [2:0] OP_ACK_TIMEOUT = 3'd3;
    localparam logic [2:0] OP_BACKOFF_EXP = 3'd4;
    localparam logic [2:0] OP_RETX_EXP    = 3'd5;

    localparam logic [2:0] CMD_CS            = 3'd0;
    localparam logic [2:0] CMD_TX            = 3'd1;
    localparam logic [2:0] CMD_ACK_TIMER     = 3'd2;
    localparam logic [2:0] CMD_BACKOFF_TIMER = 3'd3;
    localparam logic [2:0] CMD_RETX_TIMER    = 3'd4;
    localparam logic [2:0] CMD_CANCEL_ACK    = 3'd5;
    localparam logic [2:0] CMD_REPORT        = 3'd6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BACKOFFS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TICKS    = 2'd2;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 88;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] frame;     // bytes[15:0], dest[23:16], src[31:24]
        logic        busy;
        logic [7:0]  ack_from;
        logic [7:0]  ack_to;
        logic [31:0] ack_seq;
    } event_t;

endpackage
`default_nettype wire

// File: design/csma_mac_front.sv
// Front end: takes input beats, drops meaningless operations, queues events.
`timescale 1ns / 1ps
`default_nettype none
module csma_mac_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // bytes[15:0] dest[23:16] src[31:24] busy[32] ack_from[40:33] ack_to[48:41]
    // ack_seq[80:49]
    input  wire logic [csma_mac_pkg::IN_DATA_W-1:0]  s_tdata,
    // operation[2:0]
    input  wire logic [2:0]                          s_tuser,
    output logic                                     ev_valid,
    output csma_mac_pkg::event_t                     ev,
    input  wire logic                                ev_ready
);

    csma_mac_pkg::event_t fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop, op_ok;
    csma_mac_pkg::event_t in_ev;

    always_comb begin
        op_ok = s_tuser inside {[csma_mac_pkg::OP_SUBMIT : csma_mac_pkg::OP_RETX_EXP]};
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign ev_valid = (cnt_reg != 2'd0);
    assign ev       = fifo_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready && op_ok;
    assign pop      = ev_valid && ev_ready;

    always_comb begin
        in_ev.op       = s_tuser;
        in_ev.frame    = s_tdata[31:0];
        in_ev.busy     = s_tdata[32];
        in_ev.ack_from = s_tdata[40:33];
        in_ev.ack_to   = s_tdata[48:41];
        in_ev.ack_seq  = s_tdata[80:49];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_ev;
        end
    end

endmodule
`default_nettype wire

// File: design/csma_mac_back.sv
// Back end: frame FIFO, ARQ/CSMA state machine and result register.
`timescale 1ns / 1ps
`default_nettype none
module csma_mac_back (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  ev_valid,
    input  wire csma_mac_pkg::event_t                  ev,
    output logic                                       ev_ready,
    input  wire logic                                  cfg_we,
    input  wire logic [csma_mac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [csma_mac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [csma_mac_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic [2:0]                                 m_tuser,
    output logic                                       m_tlast
);

    localparam int QA_W = csma_mac_pkg::QA_W;
    localparam int QC_W = csma_mac_pkg::QC_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CS      = 3'd1;
    localparam logic [2:0] ST_ACK     = 3'd2;
    localparam logic [2:0] ST_BACKOFF = 3'd3;
    localparam logic [2:0] ST_RETX    = 3'd4;

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_EMIT = 3'd1;
    localparam logic [2:0] E_RD   = 3'd2;
    localparam logic [2:0] E_PICK = 3'd3;

    logic [7:0]  max_att_reg, max_bo_reg;
    logic [15:0] ack_ticks_reg;

    logic [31:0] frame_mem [csma_mac_pkg::QUEUE_DEPTH];
    logic [31:0] rd_data_reg;
    logic        mem_we;

    logic [QA_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [QC_W-1:0] count_reg, count_next;
    logic [31:0] cur_frame_reg, cur_frame_next;
    logic [31:0] cur_seq_reg, cur_seq_next, seq_cnt_reg, seq_cnt_next;
    logic [7:0]  attempt_reg, attempt_next, backoff_reg, backoff_next;
    logic [2:0]  ms_reg, ms_next, eng_reg, eng_next;
    logic [2:0]  p0_cmd_reg, p0_cmd_next, p1_cmd_reg, p1_cmd_next;
    logic        p0_ok_reg, p0_ok_next, p1_ok_reg, p1_ok_next;
    logic [1:0]  pend_n_reg, pend_n_next;
    logic        pend_idx_reg, pend_idx_next;
    logic        pick_reg, pick_next;
    logic        try_pick, last_p, out_free;

    logic        out_load, out_ok, out_last, with_frame;
    logic [2:0]  out_cmd;
    logic        m_tvalid_reg;
    logic [csma_mac_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;
    logic        m_tlast_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign ev_ready = (eng_reg == E_IDLE);

    always_comb begin
        head_next = head_reg;   tail_next = tail_reg;   count_next = count_reg;
        cur_frame_next = cur_frame_reg;  cur_seq_next = cur_seq_reg;
        seq_cnt_next = seq_cnt_reg;
        attempt_next = attempt_reg;  backoff_next = backoff_reg;
        ms_next = ms_reg;  eng_next = eng_reg;
        p0_cmd_next = p0_cmd_reg;  p1_cmd_next = p1_cmd_reg;
        p0_ok_next = p0_ok_reg;    p1_ok_next = p1_ok_reg;
        pend_n_next = pend_n_reg;  pend_idx_next = pend_idx_reg;
        pick_next = pick_reg;
        try_pick = 1'b0;  mem_we = 1'b0;  last_p = 1'b0;
        out_load = 1'b0;  out_cmd = csma_mac_pkg::CMD_CS;
        out_ok = 1'b0;    out_last = 1'b0;
        case (eng_reg)
            E_IDLE: begin
                if (ev_valid) begin
                    pend_n_next = 2'd0;
                    pend_idx_next = 1'b0;
                    p0_ok_next = 1'b0;
                    p1_ok_next = 1'b0;
                    if (ev.op == csma_mac_pkg::OP_SUBMIT) begin
                        if (count_reg >= QC_W'(csma_mac_pkg::QUEUE_DEPTH)) begin
                            p0_cmd_next = csma_mac_pkg::CMD_REPORT;
                            pend_n_next = 2'd1;
                        end else begin
                            mem_we = 1'b1;
                            tail_next = (tail_reg == QA_W'(csma_mac_pkg::QUEUE_DEPTH - 1))
                                ? '0 : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    case (ms_reg)
                        ST_IDLE: begin
                            try_pick = (ev.op != csma_mac_pkg::OP_ACK);
                        end
                        ST_CS: begin
                            if (ev.op == csma_mac_pkg::OP_CS_REPLY) begin
                                if (!ev.busy) begin
                                    p0_cmd_next = csma_mac_pkg::CMD_TX;
                                    p1_cmd_next = csma_mac_pkg::CMD_ACK_TIMER;
                                    pend_n_next = 2'd2;
                                    backoff_next = 8'd0;
                                    ms_next = ST_ACK;
                                end else begin
                                    p0_cmd_next = csma_mac_pkg::CMD_RETX_TIMER;
                                    pend_n_next = 2'd1;
                                    ms_next = ST_RETX;
                                end
                            end
                        end
                        ST_ACK: begin
                            if (ev.op == csma_mac_pkg::OP_ACK_TIMEOUT) begin
                                p0_cmd_next = csma_mac_pkg::CMD_RETX_TIMER;
                                pend_n_next = 2'd1;
                                ms_next = ST_RETX;
                            end else if (ev.op == csma_mac_pkg::OP_ACK
                                         && ev.ack_from == cur_frame_reg[23:16]
                                         && ev.ack_to == cur_frame_reg[31:24]
                                         && ev.ack_seq == cur_seq_reg) begin
                                p0_cmd_next = csma_mac_pkg::CMD_CANCEL_ACK;
                                p1_cmd_next = csma_mac_pkg::CMD_REPORT;
                                p1_ok_next = 1'b1;
                                pend_n_next = 2'd2;
                                ms_next = ST_IDLE;
                                try_pick = 1'b1;
                            end
                        end
                        ST_BACKOFF: begin
                            if (ev.op == csma_mac_pkg::OP_BACKOFF_EXP) begin
                                pend_n_next = 2'd1;
                                if (backoff_reg < max_bo_reg) begin
                                    backoff_next = backoff_reg + 8'd1;
                                    ms_next = ST_CS;
                                    p0_cmd_next = csma_mac_pkg::CMD_CS;
                                end else begin
                                    ms_next = ST_BACKOFF;
                                    p0_cmd_next = csma_mac_pkg::CMD_BACKOFF_TIMER;
                                end
                            end
                        end
                        ST_RETX: begin
                            if (ev.op == csma_mac_pkg::OP_RETX_EXP) begin
                                pend_n_next = 2'd1;
                                if (attempt_reg < max_att_reg) begin
                                    attempt_next = attempt_reg + 8'd1;
                                    if (max_bo_reg != 8'd0) begin
                                        backoff_next = 8'd1;
                                        ms_next = ST_CS;
                                        p0_cmd_next = csma_mac_pkg::CMD_CS;
                                    end else begin
                                        backoff_next = 8'd0;
                                        ms_next = ST_BACKOFF;
                                        p0_cmd_next = csma_mac_pkg::CMD_BACKOFF_TIMER;
                                    end
                                end else begin
                                    p0_cmd_next = csma_mac_pkg::CMD_REPORT;
                                    ms_next = ST_IDLE;
                                    try_pick = 1'b1;
                                end
                            end
                        end
                        default: begin
                            ms_next = ms_reg;
                        end
                    endcase
                    pick_next = try_pick && (ms_next == ST_IDLE) && (count_next != '0);
                    if (pend_n_next != 2'd0) begin
                        eng_next = E_EMIT;
                    end else if (pick_next) begin
                        eng_next = E_RD;
                    end
                end
            end
            E_EMIT: begin
                if (out_free) begin
                    last_p = (pend_n_reg == 2'd1) || pend_idx_reg;
                    out_load = 1'b1;
                    out_cmd = pend_idx_reg ? p1_cmd_reg : p0_cmd_reg;
                    out_ok = pend_idx_reg ? p1_ok_reg : p0_ok_reg;
                    out_last = last_p && !pick_reg;
                    if (last_p) begin
                        pend_idx_next = 1'b0;
                        eng_next = pick_reg ? E_RD : E_IDLE;
                    end else begin
                        pend_idx_next = 1'b1;
                    end
                end
            end
            E_RD: begin
                eng_next = E_PICK;
            end
            E_PICK: begin
                if (out_free) begin
                    cur_frame_next = rd_data_reg;
                    head_next = (head_reg == QA_W'(csma_mac_pkg::QUEUE_DEPTH - 1))
                        ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    cur_seq_next = seq_cnt_reg;
                    seq_cnt_next = seq_cnt_reg + 32'd1;
                    out_load = 1'b1;
                    out_last = 1'b1;
                    if (max_att_reg != 8'd0) begin
                        attempt_next = 8'd1;
                        if (max_bo_reg != 8'd0) begin
                            backoff_next = 8'd1;
                            ms_next = ST_CS;
                            out_cmd = csma_mac_pkg::CMD_CS;
                        end else begin
                            backoff_next = 8'd0;
                            ms_next = ST_BACKOFF;
                            out_cmd = csma_mac_pkg::CMD_BACKOFF_TIMER;
                        end
                    end else begin
                        attempt_next = 8'd0;
                        ms_next = ST_IDLE;
                        out_cmd = csma_mac_pkg::CMD_REPORT;
                    end
                    pick_next = 1'b0;
                    eng_next = E_IDLE;
                end
            end
            default: begin
                eng_next = E_IDLE;
            end
        endcase
    end

    assign with_frame = (out_cmd == csma_mac_pkg::CMD_TX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_att_reg <= 8'd3;
            max_bo_reg <= 8'd3;
            ack_ticks_reg <= 16'd100;
            head_reg <= '0;  tail_reg <= '0;  count_reg <= '0;
            cur_frame_reg <= 32'd0;  cur_seq_reg <= 32'd0;  seq_cnt_reg <= 32'd0;
            attempt_reg <= 8'd0;  backoff_reg <= 8'd0;
            ms_reg <= ST_IDLE;  eng_reg <= E_IDLE;
            pend_n_reg <= 2'd0;  pend_idx_reg <= 1'b0;  pick_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    csma_mac_pkg::CFG_MAX_ATTEMPTS: max_att_reg <= cfg_wdata[7:0];
                    csma_mac_pkg::CFG_MAX_BACKOFFS: max_bo_reg <= cfg_wdata[7:0];
                    csma_mac_pkg::CFG_ACK_TICKS:    ack_ticks_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            head_reg <= head_next;  tail_reg <= tail_next;  count_reg <= count_next;
            cur_frame_reg <= cur_frame_next;  cur_seq_reg <= cur_seq_next;
            seq_cnt_reg <= seq_cnt_next;
            attempt_reg <= attempt_next;  backoff_reg <= backoff_next;
            ms_reg <= ms_next;  eng_reg <= eng_next;
            pend_n_reg <= pend_n_next;  pend_idx_reg <= pend_idx_next;
            pick_reg <= pick_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        p0_cmd_reg <= p0_cmd_next;  p1_cmd_reg <= p1_cmd_next;
        p0_ok_reg <= p0_ok_next;    p1_ok_reg <= p1_ok_next;
        if (mem_we) begin
            frame_mem[tail_reg] <= ev.frame;
        end
        rd_data_reg <= frame_mem[head_reg];
        if (out_load) begin
            m_tuser_reg <= out_cmd;
            m_tlast_reg <= out_last;
            m_tdata_reg <= {4'd0,
                out_ok,
                (out_cmd == csma_mac_pkg::CMD_ACK_TIMER) ? ack_ticks_reg : 16'd0,
                with_frame ? cur_frame_reg[31:24] : 8'd0,
                with_frame ? cur_frame_reg[23:16] : 8'd0,
                with_frame ? {cur_frame_reg[15:0], 3'b000} : 19'd0,
                with_frame ? cur_seq_reg : 32'd0};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

// File: design/csma_arq_mac_controller.sv
// Top level: CSMA MAC transmit controller with stop-and-wait ARQ.
// An input beat passes through the front-end event queue and the back-end sequencer,
// which emits results from the output register; a pickup result follows the others.
// The back end takes a new event only once all results of the last one are emitted,
// the sequencer emitting one result per cycle while the output is not stalled.
// A two-entry event queue lets input beats be taken while results stall.
// Synchronous active-low reset: idle, queues empty, registers 3/3/100.
`timescale 1ns / 1ps
`default_nettype none
module csma_arq_mac_controller (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // frame_bytes, frame_dest, frame_src, channel_busy, ack_from, ack_to, ack_seq
    input  wire logic [csma_mac_pkg::IN_DATA_W-1:0]    s_tdata,
    // operation
    input  wire logic [2:0]                            s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // tx_seq, tx_length_bits, tx_dest, tx_src, timer_ticks, report_ok
    output logic [csma_mac_pkg::OUT_DATA_W-1:0]        m_tdata,
    // command
    output logic [2:0]                                 m_tuser,
    output logic                                       m_tlast,
    input  wire logic                                  cfg_we,
    input  wire logic [csma_mac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [csma_mac_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic                 ev_valid, ev_ready;
    csma_mac_pkg::event_t ev;

    csma_mac_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .ev_valid (ev_valid),
        .ev       (ev),
        .ev_ready (ev_ready)
    );

    csma_mac_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ev_valid  (ev_valid),
        .ev        (ev),
        .ev_ready  (ev_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef ASSERT_OFF
    a_tx_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == csma_mac_pkg::CMD_TX) |-> !m_tlast)
        else $error("transmit beat marked last");
    a_len_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34:32] == 3'd0))
        else $error("length not a whole number of bytes");
    a_ticks_only_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != csma_mac_pkg::CMD_ACK_TIMER) |-> (m_tdata[82:67] == 16'd0))
        else $error("timer ticks on wrong command");
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
